@@ design/owb_pkg.sv @@
// Shared types and constants for the one-wire bus master.
// No dependencies; imported by the core, the top level and the bench.
`timescale 1ns / 1ps

package owb_pkg;

  localparam int unsigned TimeW   = 10;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 4;

  // Action codes of the command field
  localparam logic [1:0] ActNone  = 2'd0;
  localparam logic [1:0] ActReset = 2'd1;
  localparam logic [1:0] ActWrite = 2'd2;
  localparam logic [1:0] ActRead  = 2'd3;

  // Timing register indexes
  localparam logic [2:0] RegResetLow     = 3'd0;
  localparam logic [2:0] RegPresenceWait = 3'd1;
  localparam logic [2:0] RegResetTail    = 3'd2;
  localparam logic [2:0] RegShortLow     = 3'd3;
  localparam logic [2:0] RegReadSample   = 3'd4;
  localparam logic [2:0] RegReadTail     = 3'd5;
  localparam logic [2:0] RegWriteSlot    = 3'd6;
  localparam logic [2:0] RegRecovery     = 3'd7;

  typedef logic [TimeW-1:0] time_t;
  typedef time_t [NumRegs-1:0] cfg_t;

  // Register values after reset, in index order
  localparam cfg_t CfgReset = '{
    RegRecovery:     time_t'(2),
    RegWriteSlot:    time_t'(60),
    RegReadTail:     time_t'(55),
    RegReadSample:   time_t'(10),
    RegShortLow:     time_t'(2),
    RegResetTail:    time_t'(500),
    RegPresenceWait: time_t'(50),
    RegResetLow:     time_t'(500)
  };

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhRstLow  = 4'd1,
    PhRstWait = 4'd2,
    PhRstTail = 4'd3,
    PhWrLow   = 4'd4,
    PhWrSlot  = 4'd5,
    PhRdLow   = 4'd6,
    PhRdWait  = 4'd7,
    PhRdTail  = 4'd8,
    PhRecov   = 4'd9
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    time_t      timer;
    logic [2:0] bit_idx;
    logic [7:0] shift;
    logic [1:0] cmd;
    logic       presence;
    logic [7:0] rd_result;
  } state_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       presence;
  } result_t;

endpackage

@@ design/owb_core.sv @@
// Next-state and per-tick result logic of the one-wire bus master.
// Depends on owb_pkg; purely combinational, state is held by the top level.
`timescale 1ns / 1ps

module owb_core import owb_pkg::*; (
  input  state_t     state_i,
  input  cfg_t       cfg_i,
  input  logic [1:0] action_i,
  input  logic [7:0] write_data_i,
  input  logic       line_level_i,
  output state_t     state_o,
  output result_t    result_o
);

  state_t     st;
  state_t     nx;
  time_t      len;
  logic [TimeW:0] tnext;
  logic       cur_bit;
  logic       drive;
  logic       busy;
  logic       done;
  logic [2:0] nbit;

  // Start a command on an idle tick, then run the phase sequencer
  always_comb begin
    st = state_i;
    if (st.phase == PhIdle && action_i != ActNone) begin
      st.cmd     = action_i;
      st.timer   = '0;
      st.bit_idx = '0;
      case (action_i)
        ActReset: st.phase = PhRstLow;
        ActWrite: begin
          st.shift = write_data_i;
          st.phase = write_data_i[0] ? PhWrLow : PhWrSlot;
        end
        default: begin
          st.shift = '0;
          st.phase = PhRdLow;
        end
      endcase
    end

    cur_bit = st.shift[st.bit_idx];
    nbit    = st.bit_idx + 3'd1;

    // Pick the length of the phase in progress
    case (st.phase)
      PhRstLow:  len = cfg_i[RegResetLow];
      PhRstWait: len = cfg_i[RegPresenceWait];
      PhRstTail: len = cfg_i[RegResetTail];
      PhWrLow:   len = cfg_i[RegShortLow];
      PhWrSlot:  len = cfg_i[RegWriteSlot];
      PhRdLow:   len = cfg_i[RegShortLow];
      PhRdWait:  len = cfg_i[RegReadSample];
      PhRdTail:  len = cfg_i[RegReadTail];
      PhRecov:   len = cfg_i[RegRecovery];
      default:   len = time_t'(1);
    endcase

    tnext = {1'b0, st.timer} + {{TimeW{1'b0}}, 1'b1};
    nx    = st;
    busy  = (st.phase != PhIdle);
    done  = 1'b0;
    drive = (st.phase == PhRstLow) || (st.phase == PhWrLow) || (st.phase == PhRdLow) ||
            (st.phase == PhWrSlot && !cur_bit);

    if (busy) begin
      if (tnext >= {1'b0, len}) begin
        nx.timer = '0;
        case (st.phase)
          PhRstLow:  nx.phase = PhRstWait;
          PhRstWait: begin
            nx.presence = line_level_i;
            nx.phase    = PhRstTail;
          end
          PhRstTail: begin
            done     = 1'b1;
            nx.phase = PhIdle;
          end
          PhWrLow:   nx.phase = PhWrSlot;
          PhWrSlot:  nx.phase = PhRecov;
          PhRdLow:   nx.phase = PhRdWait;
          PhRdWait:  begin
            if (line_level_i) nx.shift[st.bit_idx] = 1'b1;
            nx.phase = PhRdTail;
          end
          PhRdTail:  nx.phase = PhRecov;
          PhRecov:   begin
            if (st.bit_idx == 3'd7) begin
              done       = 1'b1;
              if (st.cmd == ActRead) nx.rd_result = st.shift;
              nx.phase   = PhIdle;
              nx.bit_idx = '0;
            end else begin
              nx.bit_idx = nbit;
              if (st.cmd == ActWrite) begin
                nx.phase = st.shift[nbit] ? PhWrLow : PhWrSlot;
              end else begin
                nx.phase = PhRdLow;
              end
            end
          end
          default:   nx.phase = PhIdle;
        endcase
      end else begin
        nx.timer = tnext[TimeW-1:0];
      end
    end
  end

  assign state_o  = nx;
  assign result_o = '{
    drive_low: drive,
    busy:      busy,
    done:      done,
    read_data: nx.rd_result,
    presence:  nx.presence
  };

endmodule

@@ design/onewire_bus_master.sv @@
// One-wire bus master: each accepted item is one microsecond tick and yields one result.
// Each result is registered in the output register; throughput one item per cycle while intake is not stalled.
// A skid entry behind the result register takes one more item while a result is stalled;
// intake stalls while the skid is full and resumes once it drains.
// Reset (async, active low) sets idle, timing registers to defaults, presence level 1.
// Depends on owb_pkg and owb_core.
`timescale 1ns / 1ps

module onewire_bus_master import owb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         write_data_i,
  input  logic               line_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               drive_low_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [7:0]         read_data_o,
  output logic               presence_level_o
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    accept;
  logic    out_load;

  localparam state_t StateReset = '{
    phase:     PhIdle,
    timer:     '0,
    bit_idx:   '0,
    shift:     '0,
    cmd:       ActNone,
    presence:  1'b1,
    rd_result: '0
  };

  owb_core u_core (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .action_i     (action_i),
    .write_data_i (write_data_i),
    .line_level_i (line_level_i),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = skid_valid_q;

  // Take timing register writes; ignore indexes past the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i && cfg_index_i < CfgIdxW'(NumRegs)) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // Advance the sequencer once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payloads
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_low_o      = out_q.drive_low;
  assign busy_res_o       = out_q.busy;
  assign done_res_o       = out_q.done;
  assign read_data_o      = out_q.read_data;
  assign presence_level_o = out_q.presence;

endmodule

@@ design/owb_checker.sv @@
// Port-level checks for the one-wire bus master, bound to the top level.
// Depends only on the handshake and result ports of onewire_bus_master.
`timescale 1ns / 1ps

module owb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       drive_low_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] read_data_o,
  input logic       presence_level_o
);

  // A finishing tick is always part of a running command
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o)
    else $error("done without busy");

  // Every accepted tick leaves a result waiting next cycle
  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_low_o) &&
      $stable(busy_res_o) && $stable(read_data_o) && $stable(done_res_o) &&
      $stable(presence_level_o))
    else $error("stalled result changed");

endmodule

bind onewire_bus_master owb_checker u_owb_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking bench for onewire_bus_master: random tick streams against a cycle predictor.
// Depends on owb_pkg and the onewire_bus_master RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;
  import owb_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  // Register indexes past the last timing register, written to check they are ignored
  localparam logic [CfgIdxW-1:0] RegPastEnd = CfgIdxW'(NumRegs);
  localparam logic [CfgIdxW-1:0] RegTopIdx  = '1;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] wdata;
    logic       level;
  } tick_t;

  // DUT ports, known from time zero
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [TimeW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         action_i = ActNone;
  logic [7:0]         write_data_i = '0;
  logic               line_level_i = 1'b1;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic               drive_low_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic [7:0]         read_data_o;
  logic               presence_level_o;

  onewire_bus_master u_dut (.*);

  // Bench state
  tick_t       pending_ticks[$];
  result_t     due_outputs[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          steady = 1'b0;
  result_t     want;

  // Predictor copy of the bus master
  cfg_t       timing = CfgReset;
  phase_e     ph = PhIdle;
  time_t      tmr = '0;
  logic [2:0] bidx = '0;
  logic [7:0] shf = '0;
  logic [1:0] cmd = ActNone;
  logic       pres = 1'b1;
  logic [7:0] rd_byte = '0;

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Gap lengths: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A zero register still lasts one tick
  function automatic int unsigned dur(input time_t v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic time_t phase_span(input phase_e p);
    case (p)
      PhRstLow:  return timing[RegResetLow];
      PhRstWait: return timing[RegPresenceWait];
      PhRstTail: return timing[RegResetTail];
      PhWrLow:   return timing[RegShortLow];
      PhWrSlot:  return timing[RegWriteSlot];
      PhRdLow:   return timing[RegShortLow];
      PhRdWait:  return timing[RegReadSample];
      PhRdTail:  return timing[RegReadTail];
      PhRecov:   return timing[RegRecovery];
      default:   return time_t'(1);
    endcase
  endfunction

  // Advance the predicted master by one tick and queue the outputs it gives
  function automatic void master_tick(input logic [1:0] act, input logic [7:0] wd,
                                      input logic lvl);
    result_t r;
    time_t   len;
    r = '0;
    if (ph == PhIdle && act != ActNone) begin
      cmd  = act;
      tmr  = '0;
      bidx = '0;
      if (act == ActReset) begin
        ph = PhRstLow;
      end else if (act == ActWrite) begin
        shf = wd;
        ph  = wd[0] ? PhWrLow : PhWrSlot;
      end else begin
        shf = '0;
        ph  = PhRdLow;
      end
    end
    if (ph != PhIdle) begin
      r.busy = 1'b1;
      if (ph == PhRstLow || ph == PhWrLow || ph == PhRdLow) r.drive_low = 1'b1;
      else if (ph == PhWrSlot && !shf[bidx]) r.drive_low = 1'b1;
      len = phase_span(ph);
      if ({1'b0, tmr} + 11'd1 >= {1'b0, len}) begin
        tmr = '0;
        case (ph)
          PhRstLow:  ph = PhRstWait;
          PhRstWait: begin
            pres = lvl;
            ph   = PhRstTail;
          end
          PhRstTail: begin
            r.done = 1'b1;
            ph     = PhIdle;
          end
          PhWrLow:   ph = PhWrSlot;
          PhWrSlot:  ph = PhRecov;
          PhRdLow:   ph = PhRdWait;
          PhRdWait:  begin
            if (lvl) shf[bidx] = 1'b1;
            ph = PhRdTail;
          end
          PhRdTail:  ph = PhRecov;
          PhRecov:   begin
            if (bidx == 3'd7) begin
              r.done = 1'b1;
              if (cmd == ActRead) rd_byte = shf;
              ph   = PhIdle;
              bidx = '0;
            end else begin
              bidx = bidx + 3'd1;
              if (cmd == ActWrite) ph = shf[bidx] ? PhWrLow : PhWrSlot;
              else ph = PhRdLow;
            end
          end
          default:   ph = PhIdle;
        endcase
      end else begin
        tmr = tmr + time_t'(1);
      end
    end
    r.read_data = rd_byte;
    r.presence  = pres;
    due_outputs.push_back(r);
  endfunction

  // Driver: predict each accepted item, then load the next one after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      action_i     <= ActNone;
      write_data_i <= '0;
      line_level_i <= 1'b1;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) master_tick(action_i, write_data_i, line_level_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          action_i     <= t.act;
          write_data_i <= t.wdata;
          line_level_i <= t.level;
          in_valid_i   <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, throttle stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      recv_gap = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_outputs.size() == 0) begin
          report_mismatch("result with no prediction pending");
        end else begin
          want = due_outputs.pop_front();
          if (drive_low_o !== want.drive_low)
            report_mismatch($sformatf("drive_low %b, want %b", drive_low_o, want.drive_low));
          if (busy_res_o !== want.busy)
            report_mismatch($sformatf("busy_res %b, want %b", busy_res_o, want.busy));
          if (done_res_o !== want.done)
            report_mismatch($sformatf("done_res %b, want %b", done_res_o, want.done));
          if (read_data_o !== want.read_data)
            report_mismatch($sformatf("read_data %h, want %h", read_data_o, want.read_data));
          if (presence_level_o !== want.presence)
            report_mismatch($sformatf("presence_level %b, want %b", presence_level_o,
                                      want.presence));
        end
        results_seen++;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        recv_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        out_stall_i <= (recv_gap != 0);
      end
    end
  end

  task automatic push_tick(input logic [1:0] act, input logic [7:0] wd, input logic lvl);
    tick_t t;
    t.act   = act;
    t.wdata = wd;
    t.level = lvl;
    pending_ticks.push_back(t);
  endtask

  // Ticks a command lasts under the current timing
  function automatic int unsigned cmd_ticks(input logic [1:0] act, input logic [7:0] wd);
    int unsigned n;
    n = 0;
    case (act)
      ActReset: n = dur(timing[RegResetLow]) + dur(timing[RegPresenceWait])
                    + dur(timing[RegResetTail]);
      ActWrite: begin
        for (int b = 0; b < 8; b++)
          n += (wd[b] ? dur(timing[RegShortLow]) : 0) + dur(timing[RegWriteSlot])
               + dur(timing[RegRecovery]);
      end
      ActRead:  n = 8 * (dur(timing[RegShortLow]) + dur(timing[RegReadSample])
                    + dur(timing[RegReadTail]) + dur(timing[RegRecovery]));
      default:  n = 1;
    endcase
    return n;
  endfunction

  // Queue a command and its busy ticks; noisy busy ticks carry ignored commands
  task automatic issue_cmd(input logic [1:0] act, input logic [7:0] wd, input bit noisy);
    int unsigned n;
    logic [1:0]  a;
    n = cmd_ticks(act, wd);
    push_tick(act, wd, 1'($urandom_range(0, 1)));
    for (int unsigned i = 1; i < n; i++) begin
      a = (noisy && $urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : ActNone;
      push_tick(a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Mostly whole commands with random content, some loose random ticks
  task automatic random_ticks(input int unsigned budget);
    int unsigned sent;
    int unsigned idle;
    logic [1:0]  act;
    logic [7:0]  wd;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        act = 2'($urandom_range(1, 3));
        wd  = 8'($urandom_range(0, 255));
        sent += cmd_ticks(act, wd);
        issue_cmd(act, wd, 1'b1);
        idle = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
        repeat (idle)
          push_tick(ActNone, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent += idle;
      end else begin
        push_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // Hold the sender until every result is in and the master is idle
  task automatic drain();
    do begin
      if (ph != PhIdle && pending_ticks.size() == 0)
        push_tick(ActNone, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      @(posedge clk_i);
    end while (pending_ticks.size() != 0 || in_valid_i || due_outputs.size() != 0
               || ph != PhIdle);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input time_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < NumRegs) timing[idx[2:0]] = val;
  endtask

  // Write every timing register; optionally also the unused indexes
  task automatic program_timing(input cfg_t vals, input bit stray);
    @(posedge clk_i);
    put_reg(RegResetLow, vals[RegResetLow]);
    put_reg(RegPresenceWait, vals[RegPresenceWait]);
    put_reg(RegResetTail, vals[RegResetTail]);
    put_reg(RegShortLow, vals[RegShortLow]);
    put_reg(RegReadSample, vals[RegReadSample]);
    put_reg(RegReadTail, vals[RegReadTail]);
    put_reg(RegWriteSlot, vals[RegWriteSlot]);
    put_reg(RegRecovery, vals[RegRecovery]);
    if (stray) begin
      put_reg(RegPastEnd, '1);
      put_reg(RegTopIdx, '0);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus
  initial begin
    cfg_t dir_cfg;
    cfg_t rnd_cfg;
    // Shortest timing; zero registers behave as one tick
    dir_cfg = '0;
    dir_cfg[RegResetLow]  = time_t'(1);
    dir_cfg[RegResetTail] = time_t'(1);
    dir_cfg[RegShortLow]  = time_t'(1);
    dir_cfg[RegReadTail]  = time_t'(1);
    dir_cfg[RegWriteSlot] = time_t'(1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Power-on timing: a read runs on the register values left by reset
    issue_cmd(ActRead, 8'h00, 1'b1);
    drain();

    program_timing(dir_cfg, 1'b1);

    // Directed: reset with and without presence, commands while busy, back to back
    push_tick(ActNone, 8'hFF, 1'b1);
    push_tick(ActReset, 8'h00, 1'b1);
    push_tick(ActRead, 8'h00, 1'b0);
    push_tick(ActWrite, 8'hFF, 1'b1);
    push_tick(ActReset, 8'h00, 1'b0);
    push_tick(ActNone, 8'h00, 1'b1);
    push_tick(ActNone, 8'h00, 1'b0);
    issue_cmd(ActWrite, 8'h5A, 1'b0);
    issue_cmd(ActRead, 8'h00, 1'b0);
    drain();

    // Random short timings; one setting runs without idling
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < NumRegs; i++)
        rnd_cfg[i] = ($urandom_range(0, 4) == 0) ? time_t'($urandom_range(5, 12))
                                                 : time_t'($urandom_range(0, 4));
      program_timing(rnd_cfg, 1'b0);
      steady = (k == 2);
      random_ticks(90);
      drain();
      random_ticks(90);
      drain();
    end
    steady = 1'b0;

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
